>>> sv/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants, types and codes for the best-fit free-list allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

    // heap geometry
    localparam int HEAP_PAGES     = 64;
    localparam int PAGE_BYTES     = 4096;
    localparam int HEADER_BYTES   = 16;
    localparam int SLOT_BYTES     = 8;
    localparam int SLOTS_PER_PAGE = PAGE_BYTES / SLOT_BYTES;
    localparam int SLOTS          = HEAP_PAGES * SLOTS_PER_PAGE;
    localparam int HDR_SLOTS      = HEADER_BYTES / SLOT_BYTES;
    localparam int PAGE_PAYLOAD   = PAGE_BYTES - HEADER_BYTES;

    // widths
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int LINK_W = SLOT_W + 1;
    localparam int SPP_W  = $clog2(SLOTS_PER_PAGE);
    localparam int PAGE_W = $clog2(HEAP_PAGES + 1);
    localparam int SIZE_W = 12;
    localparam int REQ_W  = SIZE_W + 1;
    localparam int HDR_W  = SIZE_W + LINK_W;
    localparam int ADDR_W = 32;
    localparam int STAT_W = 2;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_BAD_FREE  = 2'd2;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // register index of the heap base
    localparam logic [1:0] REG_HEAP_BASE = 2'd0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FREE_WR,
        ST_WALK,
        ST_PICK,
        ST_WR_PREV,
        ST_WR_SLOT,
        ST_WR_REST,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        RES_ALLOC,
        RES_FREE,
        RES_FULL,
        RES_BAD_FREE
    } t_res;

    typedef struct packed {
        logic capture;
        logic walk_init;
        logic walk_step;
        logic pick;
        logic wr_prev;
        logic wr_slot;
        logic wr_rest;
        logic free_rd;
        logic free_wr;
        logic set_res;
        t_res res;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mode;
        logic oversize;
        logic head_empty;
        logic walk_last;
        logic no_page;
        logic free_bad;
        logic out_room;
    } t_dp_sts;

endpackage

>>> sv/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// Sequencer of the allocator: steps each request through the list walk,
// the header writes and the result hand-off.
// ----------------------------------------------------------------------------
module bffa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bffa_pkg::t_dp_sts i_sts,
    output bffa_pkg::t_dp_cmd o_cmd
);

    bffa_pkg::t_state r_state;
    bffa_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bffa_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bffa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = bffa_pkg::ST_CHECK;
                end
            end
            bffa_pkg::ST_CHECK: begin
                if (i_sts.mode == bffa_pkg::MODE_FREE) begin
                    n_state = i_sts.free_bad ? bffa_pkg::ST_DONE : bffa_pkg::ST_FREE_WR;
                end else if (i_sts.oversize) begin
                    n_state = bffa_pkg::ST_DONE;
                end else if (i_sts.head_empty) begin
                    n_state = bffa_pkg::ST_PICK;
                end else begin
                    n_state = bffa_pkg::ST_WALK;
                end
            end
            bffa_pkg::ST_FREE_WR: n_state = bffa_pkg::ST_DONE;
            bffa_pkg::ST_WALK: begin
                if (i_sts.walk_last) begin
                    n_state = bffa_pkg::ST_PICK;
                end
            end
            bffa_pkg::ST_PICK: begin
                n_state = i_sts.no_page ? bffa_pkg::ST_DONE : bffa_pkg::ST_WR_PREV;
            end
            bffa_pkg::ST_WR_PREV: n_state = bffa_pkg::ST_WR_SLOT;
            bffa_pkg::ST_WR_SLOT: n_state = bffa_pkg::ST_WR_REST;
            bffa_pkg::ST_WR_REST: n_state = bffa_pkg::ST_DONE;
            bffa_pkg::ST_DONE: begin
                if (i_sts.out_room) begin
                    n_state = bffa_pkg::ST_IDLE;
                end
            end
            default: n_state = bffa_pkg::ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.res  = bffa_pkg::RES_FREE;
        o_in_ready = 1'b0;
        unique case (r_state)
            bffa_pkg::ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            bffa_pkg::ST_CHECK: begin
                if (i_sts.mode == bffa_pkg::MODE_FREE) begin
                    if (i_sts.free_bad) begin
                        o_cmd.set_res = 1'b1;
                        o_cmd.res     = bffa_pkg::RES_BAD_FREE;
                    end else begin
                        o_cmd.free_rd = 1'b1;
                    end
                end else if (i_sts.oversize) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = bffa_pkg::RES_FULL;
                end else if (!i_sts.head_empty) begin
                    o_cmd.walk_init = 1'b1;
                end
            end
            bffa_pkg::ST_FREE_WR: begin
                o_cmd.free_wr = 1'b1;
                o_cmd.set_res = 1'b1;
                o_cmd.res     = bffa_pkg::RES_FREE;
            end
            bffa_pkg::ST_WALK: o_cmd.walk_step = 1'b1;
            bffa_pkg::ST_PICK: begin
                if (i_sts.no_page) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res     = bffa_pkg::RES_FULL;
                end else begin
                    o_cmd.pick = 1'b1;
                end
            end
            bffa_pkg::ST_WR_PREV: o_cmd.wr_prev = 1'b1;
            bffa_pkg::ST_WR_SLOT: o_cmd.wr_slot = 1'b1;
            bffa_pkg::ST_WR_REST: begin
                o_cmd.wr_rest = 1'b1;
                o_cmd.set_res = 1'b1;
                o_cmd.res     = bffa_pkg::RES_ALLOC;
            end
            bffa_pkg::ST_DONE: o_cmd.out_load = i_sts.out_room;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> sv/bffa_dp.sv
// ----------------------------------------------------------------------------
// bffa_dp
// Datapath of the allocator: header store, list head, page count, the
// best-fit tracking registers and the result register.
// ----------------------------------------------------------------------------
module bffa_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  bffa_pkg::t_dp_cmd                   i_cmd,
    output bffa_pkg::t_dp_sts                   o_sts,
    input  logic                                i_mode,
    input  logic [bffa_pkg::SIZE_W-1:0]         i_req_size,
    input  logic [bffa_pkg::ADDR_W-1:0]         i_free_addr,
    input  logic                                i_cfg_we,
    input  logic [bffa_pkg::ADDR_W-1:0]         i_cfg_wdata,
    output logic [bffa_pkg::ADDR_W-1:0]         o_heap_base,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [bffa_pkg::ADDR_W-1:0]         o_block_addr,
    output logic [bffa_pkg::STAT_W-1:0]         o_status
);

    localparam int SLOT_W = bffa_pkg::SLOT_W;
    localparam int LINK_W = bffa_pkg::LINK_W;
    localparam int SIZE_W = bffa_pkg::SIZE_W;
    localparam int REQ_W  = bffa_pkg::REQ_W;
    localparam int HDR_W  = bffa_pkg::HDR_W;
    localparam int ADDR_W = bffa_pkg::ADDR_W;
    localparam int PAGE_W = bffa_pkg::PAGE_W;

    // header store
    logic [HDR_W-1:0]  r_mem [bffa_pkg::SLOTS];
    logic [HDR_W-1:0]  r_rdata;
    logic [SLOT_W-1:0] raddr;
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [HDR_W-1:0]  wdata;

    // persistent state
    logic [ADDR_W-1:0] r_base;
    logic [LINK_W-1:0] r_head;
    logic [PAGE_W-1:0] r_pages;

    // request and walk registers
    logic              r_mode;
    logic [REQ_W-1:0]  r_size;
    logic [ADDR_W-1:0] r_faddr;
    logic [LINK_W-1:0] r_cur;
    logic [LINK_W-1:0] r_prev;
    logic [SIZE_W-1:0] r_prev_size;
    logic [SLOT_W-1:0] r_steps;
    logic [LINK_W-1:0] r_best;
    logic [LINK_W-1:0] r_best_prev;
    logic [SIZE_W-1:0] r_best_prev_size;
    logic [SIZE_W-1:0] r_best_size;
    logic [LINK_W-1:0] r_best_link;
    logic [SLOT_W-1:0] r_slot;

    // pending result and output register
    logic [ADDR_W-1:0] r_res_addr;
    logic [bffa_pkg::STAT_W-1:0] r_res_status;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [bffa_pkg::STAT_W-1:0] r_out_status;

    // combinational helpers
    logic [SIZE_W-1:0] rd_size;
    logic [LINK_W-1:0] rd_link;
    logic [REQ_W-1:0]  round_sum;
    logic [REQ_W-1:0]  round_size;
    logic [SIZE_W-1:0] size12;
    logic              fit;
    logic [SLOT_W-1:0] page_slot;
    logic [SIZE_W-1:0] remaining;
    logic              split;
    logic [LINK_W-1:0] rest;
    logic              rest_ok;
    logic [ADDR_W:0]   free_lo;
    logic [ADDR_W:0]   free_off;
    logic [SLOT_W-1:0] free_slot;

    assign rd_size = r_rdata[SIZE_W-1:0];
    assign rd_link = r_rdata[HDR_W-1:SIZE_W];

    // request size rounded up to whole slots, zero taken as one slot
    assign round_sum  = {1'b0, i_req_size} + REQ_W'(7);
    assign round_size = (i_req_size == '0) ? REQ_W'(bffa_pkg::SLOT_BYTES)
                                           : (round_sum & ~REQ_W'(7));
    assign size12 = r_size[SIZE_W-1:0];

    // best-fit test, earliest block wins a tie
    assign fit = ({1'b0, rd_size} >= r_size)
              && ((r_best == '0) || (rd_size < r_best_size));

    assign page_slot = SLOT_W'(SLOT_W'(r_pages) << bffa_pkg::SPP_W);

    // split of the chosen block
    assign remaining = r_best_size - size12;
    assign split     = remaining > SIZE_W'(bffa_pkg::HEADER_BYTES);
    assign rest      = LINK_W'(r_slot) + LINK_W'(bffa_pkg::HDR_SLOTS) + LINK_W'(size12 >> 3);
    assign rest_ok   = split && (rest < LINK_W'(bffa_pkg::SLOTS));

    // free address decode
    assign free_lo   = {1'b0, r_base} + (ADDR_W+1)'(bffa_pkg::HEADER_BYTES);
    assign free_off  = {1'b0, r_faddr} - free_lo;
    assign free_slot = free_off[SLOT_W+2:3];

    // status to the controller
    always_comb begin
        o_sts.mode       = r_mode;
        o_sts.oversize   = r_size > REQ_W'(bffa_pkg::PAGE_PAYLOAD);
        o_sts.head_empty = r_head == '0;
        o_sts.walk_last  = (rd_link == '0)
                        || (rd_link > LINK_W'(bffa_pkg::SLOTS))
                        || ((LINK_W'(r_steps) + LINK_W'(1)) == LINK_W'(bffa_pkg::SLOTS));
        o_sts.no_page    = (r_best == '0) && (r_pages >= PAGE_W'(bffa_pkg::HEAP_PAGES));
        o_sts.free_bad   = ({1'b0, r_faddr} < free_lo)
                        || (free_off[2:0] != 3'd0)
                        || (free_off[ADDR_W:3] >= (ADDR_W-2)'(bffa_pkg::SLOTS));
        o_sts.out_room   = !r_out_valid || i_out_ready;
    end

    // read address select
    always_comb begin
        priority if (i_cmd.free_rd) begin
            raddr = free_slot;
        end else if (i_cmd.walk_init) begin
            raddr = SLOT_W'(r_head - LINK_W'(1));
        end else begin
            raddr = SLOT_W'(rd_link - LINK_W'(1));
        end
    end

    // header write select
    always_comb begin
        we    = 1'b0;
        waddr = r_slot;
        wdata = '0;
        priority if (i_cmd.wr_prev) begin
            we    = r_best_prev != '0;
            waddr = SLOT_W'(r_best_prev - LINK_W'(1));
            wdata = {r_best_link, r_best_prev_size};
        end else if (i_cmd.wr_slot) begin
            we    = 1'b1;
            wdata = {LINK_W'(0), split ? size12 : r_best_size};
        end else if (i_cmd.wr_rest) begin
            we    = rest_ok;
            waddr = rest[SLOT_W-1:0];
            wdata = {r_head, SIZE_W'(remaining - SIZE_W'(bffa_pkg::HEADER_BYTES))};
        end else if (i_cmd.free_wr) begin
            we    = 1'b1;
            wdata = {r_head, rd_size};
        end
    end

    // header store ports
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    // heap state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_head  <= '0;
            r_pages <= '0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_wdata;
            end
            if (i_cmd.pick && (r_best == '0)) begin
                r_pages <= r_pages + PAGE_W'(1);
            end
            priority if (i_cmd.wr_prev && (r_best_prev == '0)) begin
                r_head <= r_best_link;
            end else if (i_cmd.wr_rest && rest_ok) begin
                r_head <= rest + LINK_W'(1);
            end else if (i_cmd.free_wr) begin
                r_head <= LINK_W'(r_slot) + LINK_W'(1);
            end
        end
    end

    // request capture, walk and pick
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode  <= i_mode;
            r_size  <= round_size;
            r_faddr <= i_free_addr;
            r_best  <= '0;
        end
        if (i_cmd.walk_init) begin
            r_cur   <= r_head;
            r_prev  <= '0;
            r_steps <= '0;
        end
        if (i_cmd.walk_step) begin
            if (fit) begin
                r_best           <= r_cur;
                r_best_prev      <= r_prev;
                r_best_prev_size <= r_prev_size;
                r_best_size      <= rd_size;
                r_best_link      <= rd_link;
            end
            r_prev      <= r_cur;
            r_prev_size <= rd_size;
            r_cur       <= rd_link;
            r_steps     <= r_steps + SLOT_W'(1);
        end
        if (i_cmd.pick) begin
            if (r_best == '0) begin
                r_slot      <= page_slot;
                r_best_prev <= '0;
                r_best_link <= r_head;
                r_best_size <= SIZE_W'(bffa_pkg::PAGE_PAYLOAD);
            end else begin
                r_slot <= SLOT_W'(r_best - LINK_W'(1));
            end
        end
        if (i_cmd.free_rd) begin
            r_slot <= free_slot;
        end
    end

    // pending result
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            unique case (i_cmd.res)
                bffa_pkg::RES_ALLOC: begin
                    r_res_addr   <= r_base + ADDR_W'({r_slot, 3'b000})
                                  + ADDR_W'(bffa_pkg::HEADER_BYTES);
                    r_res_status <= bffa_pkg::STATUS_OK;
                end
                bffa_pkg::RES_FREE: begin
                    r_res_addr   <= '0;
                    r_res_status <= bffa_pkg::STATUS_OK;
                end
                bffa_pkg::RES_FULL: begin
                    r_res_addr   <= '0;
                    r_res_status <= bffa_pkg::STATUS_EXHAUSTED;
                end
                bffa_pkg::RES_BAD_FREE: begin
                    r_res_addr   <= '0;
                    r_res_status <= bffa_pkg::STATUS_BAD_FREE;
                end
                default: begin
                    r_res_addr   <= '0;
                    r_res_status <= bffa_pkg::STATUS_OK;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_addr   <= r_res_addr;
            r_out_status <= r_res_status;
        end
    end

    assign o_heap_base  = r_base;
    assign o_out_valid  = r_out_valid;
    assign o_block_addr = r_out_addr;
    assign o_status     = r_out_status;

endmodule

>>> sv/best_fit_free_list_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_free_list_allocator
// Best-fit heap allocator over a free list of page-based blocks.
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tuser mode, tdata size+address
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata address+status
// apb       in   psel, penable, pwrite, pready  heap_base at byte address 0
//
// allocate: check, walk of the free list (one header store read per cycle),
// pick and the writes of the previous link, the slot and the rest header;
// free: check and header write; oversize request or bad free address: check
// alone; no page left: check, walk and pick. the input reopens the cycle after
// the result is loaded, so the result register lets the next request start
// while a result waits on m_axis_tready; a second result then holds the
// sequencer until there is room. synchronous active-low reset empties the list
// and the page count; the header store is not cleared.
// ----------------------------------------------------------------------------
module best_fit_free_list_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // request_size [11:0], free_address [43:12]
    input  logic        s_axis_tuser,   // mode [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // block_address [31:0], status [33:32]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    bffa_pkg::t_dp_cmd cmd;
    bffa_pkg::t_dp_sts sts;
    logic              cfg_we;
    logic [31:0]       heap_base;
    logic [31:0]       block_addr;
    logic [1:0]        status;

    // register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == bffa_pkg::REG_HEAP_BASE);
    assign prdata = (paddr == bffa_pkg::REG_HEAP_BASE) ? heap_base : 32'd0;

    bffa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bffa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_mode       (s_axis_tuser),
        .i_req_size   (s_axis_tdata[11:0]),
        .i_free_addr  (s_axis_tdata[43:12]),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (pwdata),
        .o_heap_base  (heap_base),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_block_addr (block_addr),
        .o_status     (status)
    );

    assign m_axis_tdata = {6'd0, status, block_addr};

    // a request accepted keeps the input closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input open right after accepting a word");

    // status code is always a defined one
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[33:32] != 2'd3))
        else $error("undefined status code");

    // failures carry a zero address
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[33:32] != bffa_pkg::STATUS_OK))
        |-> (m_axis_tdata[31:0] == 32'd0))
        else $error("failure word with non-zero address");

    // a free rejected as bad is decided in the check cycle
    a_bad_free_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.set_res && (cmd.res == bffa_pkg::RES_BAD_FREE)) |-> sts.free_bad)
        else $error("bad free result without a bad address");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the best-fit free-list allocator. A directed table
// covers size and address extremes, rounding, oversize and rejected frees; a
// random part then mixes allocations, frees of live blocks and noise under
// several heap bases. Results are checked against typed rows or a bench model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 560;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // request_size [11:0], free_address [43:12]
    logic        s_axis_tuser;   // mode [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // block_address [31:0], status [33:32]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    typedef struct {
        logic [31:0] addr;
        logic [1:0]  status;
    } t_alloc_result;

    typedef struct {
        logic        mode;
        logic [11:0] size;
        logic [31:0] faddr;
        bit          typed;
        logic [31:0] exp_addr;
        logic [1:0]  exp_status;
    } t_row;

    // model state
    int unsigned  hdr_size [bffa_pkg::SLOTS];
    int unsigned  hdr_link [bffa_pkg::SLOTS];
    int unsigned  model_head;
    int unsigned  pages_taken;
    logic [31:0]  base_reg;

    t_alloc_result pending_results[$];
    logic [31:0]   live_blocks[$];
    int  fails;
    int  words_in, words_out, n_full, n_bad_free, n_alloc_ok;
    bit  hold_req, hold_done, no_gaps;

    best_fit_free_list_allocator DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // allocator model: one request in, one result out
    function automatic void model_request(input logic mode, input logic [11:0] rsize,
                                          input logic [31:0] faddr,
                                          output t_alloc_result res);
        logic [32:0] lo, a, off;
        int unsigned size, cur, prv, best, best_prev, best_size, steps;
        int unsigned remaining, slot, rest, s;
        res.addr = '0;
        res.status = bffa_pkg::STATUS_OK;
        if (mode == bffa_pkg::MODE_FREE) begin
            a  = {1'b0, faddr};
            lo = {1'b0, base_reg} + bffa_pkg::HEADER_BYTES;
            if (a < lo) begin
                res.status = bffa_pkg::STATUS_BAD_FREE;
                return;
            end
            off = a - lo;
            if (off[2:0] != 3'd0 || (off >> 3) >= bffa_pkg::SLOTS) begin
                res.status = bffa_pkg::STATUS_BAD_FREE;
                return;
            end
            slot = off >> 3;
            hdr_link[slot] = model_head;
            model_head = slot + 1;
            return;
        end
        size = (rsize + 7) & ~32'd7;
        if (size == 0) size = 8;
        if (size > bffa_pkg::PAGE_PAYLOAD) begin
            res.status = bffa_pkg::STATUS_EXHAUSTED;
            return;
        end
        cur = model_head; prv = 0; best = 0; best_prev = 0; best_size = 0; steps = 0;
        // best-fit walk, earliest block wins a tie
        while (cur != 0 && cur <= bffa_pkg::SLOTS && steps < bffa_pkg::SLOTS) begin
            s = hdr_size[cur-1];
            if (s >= size && (best == 0 || s < best_size)) begin
                best = cur; best_prev = prv; best_size = s;
            end
            prv = cur;
            cur = hdr_link[cur-1];
            steps++;
        end
        // nothing fits: open a fresh page
        if (best == 0) begin
            if (pages_taken >= bffa_pkg::HEAP_PAGES) begin
                res.status = bffa_pkg::STATUS_EXHAUSTED;
                return;
            end
            slot = pages_taken * bffa_pkg::SLOTS_PER_PAGE;
            pages_taken++;
            hdr_size[slot] = bffa_pkg::PAGE_PAYLOAD;
            hdr_link[slot] = model_head;
            model_head = slot + 1;
            best = slot + 1; best_prev = 0; best_size = bffa_pkg::PAGE_PAYLOAD;
        end
        slot = best - 1;
        remaining = best_size - size;
        if (best_prev != 0) hdr_link[best_prev-1] = hdr_link[slot];
        else model_head = hdr_link[slot];
        hdr_link[slot] = 0;
        // split off the tail when worth a header
        if (remaining > bffa_pkg::HEADER_BYTES) begin
            rest = slot + bffa_pkg::HDR_SLOTS + size / bffa_pkg::SLOT_BYTES;
            hdr_size[slot] = size & 12'hFFF;
            if (rest < bffa_pkg::SLOTS) begin
                hdr_size[rest] = (remaining - bffa_pkg::HEADER_BYTES) & 12'hFFF;
                hdr_link[rest] = model_head;
                model_head = rest + 1;
            end
        end
        res.addr = base_reg + slot * bffa_pkg::SLOT_BYTES + bffa_pkg::HEADER_BYTES;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // offer one request word and book its expected result
    task automatic send_request(input t_row row);
        t_alloc_result res;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= row.mode;
        s_axis_tdata  <= {4'b0, row.faddr, row.size};
        do @(posedge i_clk); while (!s_axis_tready);
        words_in++;
        model_request(row.mode, row.size, row.faddr, res);
        if (row.typed) begin
            res.addr = row.exp_addr;
            res.status = row.exp_status;
        end
        pending_results.push_back(res);
        if (res.status == bffa_pkg::STATUS_EXHAUSTED) n_full++;
        if (res.status == bffa_pkg::STATUS_BAD_FREE) n_bad_free++;
        if (row.mode == bffa_pkg::MODE_ALLOC && res.status == bffa_pkg::STATUS_OK) begin
            live_blocks.push_back(res.addr);
            n_alloc_ok++;
        end
        if (row.mode == bffa_pkg::MODE_FREE)
            foreach (live_blocks[k])
                if (live_blocks[k] == row.faddr) begin
                    live_blocks.delete(k);
                    break;
                end
    endtask

    task automatic idle_gap();
        int n;
        n = pick_gap();
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // register write then read back
    task automatic set_heap_base(input logic [31:0] value);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= bffa_pkg::REG_HEAP_BASE; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        base_reg = value;
        psel <= 1'b1; pwrite <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value) begin
            $display("%0t: heap_base readback expected %h actual %h", $time, value, prdata);
            fails++;
        end
        psel <= 1'b0; penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_row random_row();
        t_row row;
        logic [32:0] lo, off;
        int r, k;
        r = $urandom_range(0, 99);
        row = '{bffa_pkg::MODE_ALLOC, 12'd8, 32'd0, 1'b0, 32'd0, bffa_pkg::STATUS_OK};
        row.faddr = $urandom;
        row.size = 12'($urandom);
        if (r < 4) begin
            // rejected free: make sure the address is really rejected
            row.mode = bffa_pkg::MODE_FREE;
            lo = {1'b0, base_reg} + bffa_pkg::HEADER_BYTES;
            off = {1'b0, row.faddr} - lo;
            if ({1'b0, row.faddr} >= lo && off[2:0] == 3'd0 && (off >> 3) < bffa_pkg::SLOTS)
                row.faddr[0] = ~row.faddr[0];
        end else if (r < 7) begin
            row.mode = bffa_pkg::MODE_ALLOC;
        end else if (live_blocks.size() != 0 && (r < 50 || live_blocks.size() > 48)) begin
            row.mode = bffa_pkg::MODE_FREE;
            k = $urandom_range(0, live_blocks.size() - 1);
            row.faddr = live_blocks[k];
        end else begin
            row.mode = bffa_pkg::MODE_ALLOC;
            k = $urandom_range(0, 9);
            if (k < 7) row.size = 12'($urandom_range(1, 8) * 8);
            else if (k < 9) row.size = 12'($urandom_range(1, 64) * 8);
            else row.size = 12'($urandom_range(1, 500) * 8);
        end
        return row;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_out++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %h", $time, m_axis_tdata);
                fails++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== want.addr) begin
                    $display("%0t: block_address expected %h actual %h", $time,
                             want.addr, m_axis_tdata[31:0]);
                    fails++;
                end
                if (m_axis_tdata[33:32] !== want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, m_axis_tdata[33:32]);
                    fails++;
                end
            end
        end
    end

    // watchdog on cycles with no word moving
    always @(posedge i_clk) begin
        int idle_cycles;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("best_fit_free_list_allocator verification failed");
            $finish;
        end
    end

    // receiver stalls, with one long hold-off
    initial begin
        int n;
        m_axis_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_done = 1'b1;
            end else begin
                n = pick_gap();
                if (n > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (n) @(posedge i_clk);
                end
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    // main sequence
    initial begin
        t_row rows[$];
        logic [31:0] bases[3];
        t_row row;
        fails = 0; words_in = 0; words_out = 0; n_full = 0; n_bad_free = 0; n_alloc_ok = 0;
        hold_req = 0; hold_done = 0; no_gaps = 0;
        model_head = 0; pages_taken = 0; base_reg = '0;
        s_axis_tvalid <= 1'b0; s_axis_tdata <= '0; s_axis_tuser <= 1'b0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_heap_base(32'h0);

        // directed table: mode, size, address, typed, address, status
        rows = '{
            '{bffa_pkg::MODE_ALLOC, 12'd8,    32'd0,        1'b1, 32'd16,
              bffa_pkg::STATUS_OK},
            '{bffa_pkg::MODE_ALLOC, 12'd0,    32'd0,        1'b0, 32'd0,
              bffa_pkg::STATUS_OK},
            '{bffa_pkg::MODE_ALLOC, 12'd13,   32'd0,        1'b0, 32'd0,
              bffa_pkg::STATUS_OK},
            '{bffa_pkg::MODE_ALLOC, 12'd4080, 32'd0,        1'b1, 32'd4112,
              bffa_pkg::STATUS_OK},
            '{bffa_pkg::MODE_ALLOC, 12'd4081, 32'd0,        1'b1, 32'd0,
              bffa_pkg::STATUS_EXHAUSTED},
            '{bffa_pkg::MODE_ALLOC, 12'd4095, 32'hFFFFFFFF, 1'b1, 32'd0,
              bffa_pkg::STATUS_EXHAUSTED},
            '{bffa_pkg::MODE_ALLOC, 12'd4088, 32'd0,        1'b1, 32'd0,
              bffa_pkg::STATUS_EXHAUSTED},
            '{bffa_pkg::MODE_ALLOC, 12'd4000, 32'd0,        1'b0, 32'd0,
              bffa_pkg::STATUS_OK},
            '{bffa_pkg::MODE_FREE,  12'd0,    32'd16,       1'b1, 32'd0,
              bffa_pkg::STATUS_OK},
            '{bffa_pkg::MODE_FREE,  12'hFFF,  32'd0,        1'b1, 32'd0,
              bffa_pkg::STATUS_BAD_FREE},
            '{bffa_pkg::MODE_FREE,  12'd0,    32'd20,       1'b1, 32'd0,
              bffa_pkg::STATUS_BAD_FREE},
            '{bffa_pkg::MODE_FREE,  12'd0,    32'h00040010, 1'b1, 32'd0,
              bffa_pkg::STATUS_BAD_FREE},
            '{bffa_pkg::MODE_FREE,  12'd0,    32'hFFFFFFFF, 1'b1, 32'd0,
              bffa_pkg::STATUS_BAD_FREE},
            '{bffa_pkg::MODE_ALLOC, 12'd8,    32'd0,        1'b0, 32'd0,
              bffa_pkg::STATUS_OK},
            '{bffa_pkg::MODE_ALLOC, 12'd1,    32'd0,        1'b0, 32'd0,
              bffa_pkg::STATUS_OK},
            '{bffa_pkg::MODE_ALLOC, 12'd16,   32'd0,        1'b0, 32'd0,
              bffa_pkg::STATUS_OK}
        };
        foreach (rows[i]) begin
            send_request(rows[i]);
            idle_gap();
        end
        drain();

        // random phases under different heap bases
        bases[0] = 32'hFFFC0000;
        bases[1] = $urandom_range(0, 32'h3FFFC) << 12;
        bases[2] = 32'h00010000;
        for (int p = 0; p < 3; p++) begin
            set_heap_base(bases[p]);
            live_blocks.delete();
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (p == 0 && i == 100) hold_req = 1'b1;
                no_gaps = (i % 200) >= 160;
                row = random_row();
                send_request(row);
                idle_gap();
            end
            // run the heap dry in the last phase
            if (p == 2)
                for (int i = 0; i < 80; i++) begin
                    row = '{bffa_pkg::MODE_ALLOC, 12'd4000, 32'd0, 1'b0, 32'd0,
                            bffa_pkg::STATUS_OK};
                    send_request(row);
                    idle_gap();
                end
            drain();
        end

        repeat (50) @(posedge i_clk);
        $display("run: %0d request words, %0d result words, %0d allocations granted",
                 words_in, words_out, n_alloc_ok);
        $display("run: %0d exhausted, %0d rejected frees, four heap bases, one long stall",
                 n_full, n_bad_free);
        if (fails == 0)
            $display("best_fit_free_list_allocator verification clean");
        else
            $display("best_fit_free_list_allocator verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/bffa_pkg.sv
sv/bffa_ctrl.sv
sv/bffa_dp.sv
sv/best_fit_free_list_allocator.sv
sim/testbench.sv
